/* rtl/assert_macros.svh */
// Assertion helpers included by moving_dash_pattern_core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge of aclk outside reset.
`define ASSERT_CLK(name, prop, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);

// Checked on every rising edge of aclk, reset included.
`define ASSERT_CLK_ALWAYS(name, prop, msg) \
    name: assert property (@(posedge aclk) prop) \
        else $error(msg);

`endif

/* rtl/mdp_pkg.sv */
package mdp_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int FRAC_W     = FRAC_BITS + 1;
    localparam int MAX_PIXELS = 1024;
    localparam int IDX_W      = 10;
    localparam int CNT_W      = 11;
    localparam int TIME_W     = 32;
    localparam int SUM_W      = TIME_W + 1;
    localparam int CH_W       = 8;
    localparam int NUM_CH     = 3;
    localparam int COLOR_W    = CH_W * NUM_CH;
    localparam int CFG_W      = 24;
    localparam int REG_IDX_W  = 3;

    localparam int POS_STEPS   = FRAC_BITS;
    localparam int MOD_STEPS   = TIME_W;
    localparam int PHASE_STEPS = FRAC_BITS;
    localparam int TERM_STEPS  = FRAC_BITS;

    localparam logic [FRAC_W-1:0]    ONE       = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic [FRAC_BITS-1:0] HALF      = {1'b1, {(FRAC_BITS - 1){1'b0}}};
    localparam logic [CNT_W-1:0]     MAX_COUNT = CNT_W'(MAX_PIXELS);

    // Register indexes of the configuration port.
    localparam logic [REG_IDX_W-1:0] REG_PIXEL_COUNT      = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_GAP_FRACTION     = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_DASH_SIZE        = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_FADE_AMOUNT      = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_BRIGHTNESS_GAIN  = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_DASH_COLOR       = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_BACKGROUND_COLOR = 3'd6;

    // Reset values of the registers.
    localparam logic [CNT_W-1:0]   RST_PIXEL_COUNT      = 11'd64;
    localparam logic [FRAC_W-1:0]  RST_GAP_FRACTION     = 17'd16384;
    localparam logic [FRAC_W-1:0]  RST_DASH_SIZE        = 17'd32768;
    localparam logic [FRAC_W-1:0]  RST_FADE_AMOUNT      = 17'd65536;
    localparam logic [FRAC_W-1:0]  RST_BRIGHTNESS_GAIN  = 17'd65536;
    localparam logic [COLOR_W-1:0] RST_DASH_COLOR       = 24'hFFFFFF;
    localparam logic [COLOR_W-1:0] RST_BACKGROUND_COLOR = 24'h000000;

    // Configuration as seen by the pipeline, with count, fade and gain saturated.
    typedef struct packed {
        logic [CNT_W-1:0]   count;
        logic [FRAC_W-1:0]  gap;
        logic [FRAC_W-1:0]  size;
        logic [FRAC_W-1:0]  fade;
        logic [FRAC_W-1:0]  gain;
        logic [COLOR_W-1:0] dash;
        logic [COLOR_W-1:0] back;
    } cfg_t;

    // Control that travels with every pixel; bg forces the background color.
    typedef struct packed {
        logic             valid;
        logic [IDX_W-1:0] idx;
        logic             bg;
    } item_ctl_t;

    typedef struct packed {
        logic [IDX_W-1:0]   idx;
        logic [COLOR_W-1:0] rgb;
        logic               lit;
    } out_item_t;

endpackage

/* rtl/mdp_position.sv */
module mdp_position (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    en,
    input  mdp_pkg::cfg_t                           cfg,
    input  mdp_pkg::item_ctl_t                      in_ctl,
    input  logic signed [mdp_pkg::TIME_W-1:0]       in_time,
    output mdp_pkg::item_ctl_t                      out_ctl,
    output logic signed [mdp_pkg::TIME_W-1:0]       out_time,
    output logic [mdp_pkg::FRAC_W-1:0]              out_pos
);
    import mdp_pkg::*;

    localparam int LAST = POS_STEPS - 1;

    item_ctl_t                 ctl_reg  [POS_STEPS];
    logic [IDX_W-1:0]          rem_reg  [POS_STEPS];
    logic [FRAC_BITS-1:0]      quo_reg  [POS_STEPS];
    logic signed [TIME_W-1:0]  time_reg [POS_STEPS];

    item_ctl_t                 ctl_o_reg;
    logic signed [TIME_W-1:0]  time_o_reg;
    logic [FRAC_W-1:0]         pos_reg;

    // Long division idx * ONE / count, one quotient bit per stage.
    for (genvar k = 0; k < POS_STEPS; k++) begin : g_step
        item_ctl_t                ctl_src;
        logic [IDX_W-1:0]         rem_src;
        logic [FRAC_BITS-1:0]     quo_src;
        logic signed [TIME_W-1:0] time_src;
        logic [CNT_W-1:0]         shifted;
        logic                     ge;

        if (k == 0) begin : g_first
            always_comb begin
                ctl_src    = in_ctl;
                ctl_src.bg = in_ctl.bg | ({1'b0, in_ctl.idx} >= cfg.count);
                rem_src    = in_ctl.idx;
                quo_src    = '0;
                time_src   = in_time;
            end
        end else begin : g_next
            assign ctl_src  = ctl_reg[k-1];
            assign rem_src  = rem_reg[k-1];
            assign quo_src  = quo_reg[k-1];
            assign time_src = time_reg[k-1];
        end

        assign shifted = {rem_src, 1'b0};
        assign ge      = shifted >= cfg.count;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                ctl_reg[k].valid <= 1'b0;
            end else if (en) begin
                ctl_reg[k]  <= ctl_src;
                rem_reg[k]  <= ge ? IDX_W'(shifted - cfg.count) : shifted[IDX_W-1:0];
                quo_reg[k]  <= {quo_src[FRAC_BITS-2:0], ge};
                time_reg[k] <= time_src;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_o_reg.valid <= 1'b0;
        end else if (en) begin
            ctl_o_reg  <= ctl_reg[LAST];
            time_o_reg <= time_reg[LAST];
            pos_reg    <= (ctl_reg[LAST].idx == '0) ? '0
                                                   : FRAC_W'(ONE - {1'b0, quo_reg[LAST]});
        end
    end

    assign out_ctl  = ctl_o_reg;
    assign out_time = time_o_reg;
    assign out_pos  = pos_reg;

endmodule

/* rtl/mdp_phase.sv */
module mdp_phase (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              en,
    input  mdp_pkg::cfg_t                     cfg,
    input  mdp_pkg::item_ctl_t                in_ctl,
    input  logic signed [mdp_pkg::TIME_W-1:0] in_time,
    input  logic [mdp_pkg::FRAC_W-1:0]        in_pos,
    output mdp_pkg::item_ctl_t                out_ctl,
    output logic [mdp_pkg::FRAC_W-1:0]        out_two_d
);
    import mdp_pkg::*;

    localparam int MLAST = MOD_STEPS - 1;
    localparam int PLAST = PHASE_STEPS - 1;

    item_ctl_t               sum_ctl_reg;
    logic signed [SUM_W-1:0] sum_reg;
    item_ctl_t               abs_ctl_reg;
    logic                    neg_reg;
    logic [TIME_W-1:0]       mag_reg;

    item_ctl_t               mctl_reg [MOD_STEPS];
    logic [FRAC_W-1:0]       mrem_reg [MOD_STEPS];
    logic [TIME_W-1:0]       mmag_reg [MOD_STEPS];
    logic                    mneg_reg [MOD_STEPS];

    item_ctl_t               m_ctl_reg;
    logic [FRAC_W-1:0]       m_reg;

    item_ctl_t               pctl_reg [PHASE_STEPS];
    logic [FRAC_W-1:0]       prem_reg [PHASE_STEPS];
    logic [FRAC_BITS-1:0]    pquo_reg [PHASE_STEPS];

    item_ctl_t               d_ctl_reg;
    logic [FRAC_W-1:0]       two_d_reg;

    logic [FRAC_BITS-1:0]    phase;
    logic [FRAC_BITS-1:0]    phase_dist;

    // Shifted position, then its sign and magnitude for the floored modulo.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_ctl_reg.valid <= 1'b0;
            abs_ctl_reg.valid <= 1'b0;
        end else if (en) begin
            sum_ctl_reg <= in_ctl;
            sum_reg     <= SUM_W'($signed({1'b0, in_pos})) + SUM_W'(in_time);
            abs_ctl_reg <= sum_ctl_reg;
            neg_reg     <= sum_reg[SUM_W-1];
            mag_reg     <= sum_reg[SUM_W-1] ? TIME_W'(-sum_reg) : TIME_W'(sum_reg);
        end
    end

    // Remainder of the magnitude by the gap, one dividend bit per stage.
    for (genvar k = 0; k < MOD_STEPS; k++) begin : g_mod
        item_ctl_t         ctl_src;
        logic [FRAC_W-1:0] rem_src;
        logic [TIME_W-1:0] mag_src;
        logic              neg_src;
        logic [FRAC_W:0]   shifted;
        logic              ge;

        if (k == 0) begin : g_first
            assign ctl_src = abs_ctl_reg;
            assign rem_src = '0;
            assign mag_src = mag_reg;
            assign neg_src = neg_reg;
        end else begin : g_next
            assign ctl_src = mctl_reg[k-1];
            assign rem_src = mrem_reg[k-1];
            assign mag_src = mmag_reg[k-1];
            assign neg_src = mneg_reg[k-1];
        end

        assign shifted = {rem_src, mag_src[TIME_W-1]};
        assign ge      = shifted >= {1'b0, cfg.gap};

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                mctl_reg[k].valid <= 1'b0;
            end else if (en) begin
                mctl_reg[k] <= ctl_src;
                mrem_reg[k] <= ge ? FRAC_W'(shifted - {1'b0, cfg.gap}) : shifted[FRAC_W-1:0];
                mmag_reg[k] <= {mag_src[TIME_W-2:0], 1'b0};
                mneg_reg[k] <= neg_src;
            end
        end
    end

    // A negative sum with a nonzero remainder wraps up into [0, gap).
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_ctl_reg.valid <= 1'b0;
        end else if (en) begin
            m_ctl_reg <= mctl_reg[MLAST];
            m_reg     <= (mneg_reg[MLAST] && mrem_reg[MLAST] != '0)
                         ? FRAC_W'(cfg.gap - mrem_reg[MLAST]) : mrem_reg[MLAST];
        end
    end

    // Phase m * ONE / gap; m is below the gap, so the quotient fits the fraction.
    for (genvar k = 0; k < PHASE_STEPS; k++) begin : g_div
        item_ctl_t            ctl_src;
        logic [FRAC_W-1:0]    rem_src;
        logic [FRAC_BITS-1:0] quo_src;
        logic [FRAC_W:0]      shifted;
        logic                 ge;

        if (k == 0) begin : g_first
            assign ctl_src = m_ctl_reg;
            assign rem_src = m_reg;
            assign quo_src = '0;
        end else begin : g_next
            assign ctl_src = pctl_reg[k-1];
            assign rem_src = prem_reg[k-1];
            assign quo_src = pquo_reg[k-1];
        end

        assign shifted = {rem_src, 1'b0};
        assign ge      = shifted >= {1'b0, cfg.gap};

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                pctl_reg[k].valid <= 1'b0;
            end else if (en) begin
                pctl_reg[k] <= ctl_src;
                prem_reg[k] <= ge ? FRAC_W'(shifted - {1'b0, cfg.gap}) : shifted[FRAC_W-1:0];
                pquo_reg[k] <= {quo_src[FRAC_BITS-2:0], ge};
            end
        end
    end

    assign phase      = pquo_reg[PLAST];
    assign phase_dist = (phase >= HALF) ? FRAC_BITS'(phase - HALF) : FRAC_BITS'(HALF - phase);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d_ctl_reg.valid <= 1'b0;
        end else if (en) begin
            d_ctl_reg <= pctl_reg[PLAST];
            two_d_reg <= {phase_dist, 1'b0};
        end
    end

    assign out_ctl   = d_ctl_reg;
    assign out_two_d = two_d_reg;

endmodule

/* rtl/mdp_term.sv */
module mdp_term (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       en,
    input  mdp_pkg::cfg_t              cfg,
    input  mdp_pkg::item_ctl_t         in_ctl,
    input  logic [mdp_pkg::FRAC_W-1:0] in_two_d,
    output mdp_pkg::item_ctl_t         out_ctl,
    output logic [mdp_pkg::FRAC_W-1:0] out_v
);
    import mdp_pkg::*;

    localparam int LAST = TERM_STEPS - 1;

    logic                 lt_one;
    logic                 lt_two;

    item_ctl_t            pre_ctl_reg;
    logic                 pre_hi_reg;
    logic                 pre_over_reg;
    logic [FRAC_W-1:0]    pre_rem_reg;

    item_ctl_t            ctl_reg  [TERM_STEPS];
    logic [FRAC_W-1:0]    rem_reg  [TERM_STEPS];
    logic [FRAC_BITS-1:0] quo_reg  [TERM_STEPS];
    logic                 hi_reg   [TERM_STEPS];
    logic                 over_reg [TERM_STEPS];

    item_ctl_t            v_ctl_reg;
    logic [FRAC_W-1:0]    v_reg;
    logic                 in_dash;

    // Integer part of 2d / size: only zero and one can still give a lit pixel.
    assign lt_one = in_two_d < cfg.size;
    assign lt_two = {1'b0, in_two_d} < {cfg.size, 1'b0};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pre_ctl_reg.valid <= 1'b0;
        end else if (en) begin
            pre_ctl_reg  <= in_ctl;
            pre_hi_reg   <= !lt_one;
            pre_over_reg <= !lt_two;
            pre_rem_reg  <= lt_one ? in_two_d : FRAC_W'(in_two_d - cfg.size);
        end
    end

    // Fraction bits of the quotient.
    for (genvar k = 0; k < TERM_STEPS; k++) begin : g_div
        item_ctl_t            ctl_src;
        logic [FRAC_W-1:0]    rem_src;
        logic [FRAC_BITS-1:0] quo_src;
        logic                 hi_src;
        logic                 over_src;
        logic [FRAC_W:0]      shifted;
        logic                 ge;

        if (k == 0) begin : g_first
            assign ctl_src  = pre_ctl_reg;
            assign rem_src  = pre_rem_reg;
            assign quo_src  = '0;
            assign hi_src   = pre_hi_reg;
            assign over_src = pre_over_reg;
        end else begin : g_next
            assign ctl_src  = ctl_reg[k-1];
            assign rem_src  = rem_reg[k-1];
            assign quo_src  = quo_reg[k-1];
            assign hi_src   = hi_reg[k-1];
            assign over_src = over_reg[k-1];
        end

        assign shifted = {rem_src, 1'b0};
        assign ge      = shifted >= {1'b0, cfg.size};

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                ctl_reg[k].valid <= 1'b0;
            end else if (en) begin
                ctl_reg[k]  <= ctl_src;
                rem_reg[k]  <= ge ? FRAC_W'(shifted - {1'b0, cfg.size}) : shifted[FRAC_W-1:0];
                quo_reg[k]  <= {quo_src[FRAC_BITS-2:0], ge};
                hi_reg[k]   <= hi_src;
                over_reg[k] <= over_src;
            end
        end
    end

    // The pixel lies inside a dash when the term does not exceed one.
    assign in_dash = !over_reg[LAST] && (!hi_reg[LAST] || quo_reg[LAST] == '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_ctl_reg.valid <= 1'b0;
        end else if (en) begin
            v_ctl_reg.valid <= ctl_reg[LAST].valid;
            v_ctl_reg.idx   <= ctl_reg[LAST].idx;
            v_ctl_reg.bg    <= ctl_reg[LAST].bg | !in_dash;
            v_reg           <= FRAC_W'(ONE - {hi_reg[LAST], quo_reg[LAST]});
        end
    end

    assign out_ctl = v_ctl_reg;
    assign out_v   = v_reg;

endmodule

/* rtl/mdp_shade.sv */
module mdp_shade (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       en,
    input  mdp_pkg::cfg_t              cfg,
    input  mdp_pkg::item_ctl_t         in_ctl,
    input  logic [mdp_pkg::FRAC_W-1:0] in_v,
    output logic                       out_valid,
    output mdp_pkg::out_item_t         out_item
);
    import mdp_pkg::*;

    localparam int CTL_STAGES = 6;
    localparam int PROD_W     = 2 * FRAC_W;
    localparam int CPROD_W    = CH_W + FRAC_W;

    item_ctl_t              ctl_reg [CTL_STAGES];
    logic [PROD_W-1:0]      fv_reg;
    logic [FRAC_W-1:0]      t_reg;
    logic [FRAC_W-1:0]      t2_reg;
    logic [FRAC_W-1:0]      omt_reg;
    logic [CPROD_W-1:0]     bw_reg [NUM_CH];
    logic [CPROD_W-1:0]     dw_reg [NUM_CH];
    logic [CH_W-1:0]        c_reg  [NUM_CH];
    logic [CPROD_W-1:0]     cb_reg [NUM_CH];

    logic                   out_valid_reg;
    out_item_t              out_item_reg;
    logic [COLOR_W-1:0]     lit_rgb;
    logic                   bg_final;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < CTL_STAGES; i++) begin
                ctl_reg[i].valid <= 1'b0;
            end
        end else if (en) begin
            ctl_reg[0] <= in_ctl;
            for (int i = 1; i < CTL_STAGES; i++) begin
                ctl_reg[i] <= ctl_reg[i-1];
            end
        end
    end

    // Fade mapping t = (1 - f) + v * f, then the blend weights.
    always_ff @(posedge aclk) begin
        if (en) begin
            fv_reg  <= PROD_W'(in_v) * PROD_W'(cfg.fade);
            t_reg   <= FRAC_W'({1'b0, ONE} - {1'b0, cfg.fade} + fv_reg[FRAC_BITS +: FRAC_W + 1]);
            t2_reg  <= t_reg;
            omt_reg <= FRAC_W'(ONE - t_reg);
        end
    end

    // Per channel: weighted blend, then the brightness scale.
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int ch = 0; ch < NUM_CH; ch++) begin
                bw_reg[ch] <= CPROD_W'(cfg.back[ch*CH_W +: CH_W]) * CPROD_W'(omt_reg);
                dw_reg[ch] <= CPROD_W'(cfg.dash[ch*CH_W +: CH_W]) * CPROD_W'(t2_reg);
                c_reg[ch]  <= CH_W'(({1'b0, bw_reg[ch]} + {1'b0, dw_reg[ch]}) >> FRAC_BITS);
                cb_reg[ch] <= CPROD_W'(c_reg[ch]) * CPROD_W'(cfg.gain);
            end
        end
    end

    always_comb begin
        for (int ch = 0; ch < NUM_CH; ch++) begin
            lit_rgb[ch*CH_W +: CH_W] = cb_reg[ch][FRAC_BITS +: CH_W];
        end
    end

    assign bg_final = ctl_reg[CTL_STAGES-1].bg || cfg.gap == '0 || cfg.size == '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (en) begin
            out_valid_reg    <= ctl_reg[CTL_STAGES-1].valid;
            out_item_reg.idx <= ctl_reg[CTL_STAGES-1].idx;
            out_item_reg.rgb <= bg_final ? cfg.back : lit_rgb;
            out_item_reg.lit <= !bg_final;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

/* rtl/moving_dash_pattern_core.sv */
// Moving dash pattern generator: for each pixel index and signed Q15.16 time
// it returns the pixel's RGB color and whether the pixel lies inside a dash.
// The core is a 94-stage pipeline that takes one pixel per clock while its
// skid entry is empty. The depth is set by the four long divisions (pixel
// position, the floored modulo of the shifted position by the gap, the phase
// and the dash term), each of which produces one quotient or dividend bit
// per stage. An output register plus one skid entry keep the pipeline moving
// while a result waits, until the skid entry is occupied; configuration
// registers are to be written by the user only while no pixel is in flight
// (the block itself does not enforce this) and take effect on the next transaction.
`include "assert_macros.svh"

module moving_dash_pattern_core (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [mdp_pkg::IDX_W-1:0]            s_pixel_index,
    input  logic signed [mdp_pkg::TIME_W-1:0]    s_time_phase,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [mdp_pkg::IDX_W-1:0]            m_pixel_echo,
    output logic [mdp_pkg::CH_W-1:0]             m_red,
    output logic [mdp_pkg::CH_W-1:0]             m_green,
    output logic [mdp_pkg::CH_W-1:0]             m_blue,
    output logic                                 m_lit,
    input  logic                                 cfg_wr_en,
    input  logic [mdp_pkg::REG_IDX_W-1:0]        cfg_index,
    input  logic [mdp_pkg::CFG_W-1:0]            cfg_data
);
    import mdp_pkg::*;

    logic [CNT_W-1:0]   pixel_count_reg;
    logic [FRAC_W-1:0]  gap_fraction_reg;
    logic [FRAC_W-1:0]  dash_size_reg;
    logic [FRAC_W-1:0]  fade_amount_reg;
    logic [FRAC_W-1:0]  brightness_gain_reg;
    logic [COLOR_W-1:0] dash_color_reg;
    logic [COLOR_W-1:0] background_color_reg;

    cfg_t               cfg;
    logic               pipe_en;
    item_ctl_t          in_ctl;

    item_ctl_t          pos_ctl;
    logic signed [TIME_W-1:0] pos_time;
    logic [FRAC_W-1:0]  pos_val;
    item_ctl_t          phase_ctl;
    logic [FRAC_W-1:0]  two_d;
    item_ctl_t          term_ctl;
    logic [FRAC_W-1:0]  v_val;
    logic               tail_valid;
    out_item_t          tail_item;
    logic               tail_push;

    logic               m_valid_reg;
    out_item_t          out_reg;
    logic               skid_valid_reg;
    out_item_t          skid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pixel_count_reg      <= RST_PIXEL_COUNT;
            gap_fraction_reg     <= RST_GAP_FRACTION;
            dash_size_reg        <= RST_DASH_SIZE;
            fade_amount_reg      <= RST_FADE_AMOUNT;
            brightness_gain_reg  <= RST_BRIGHTNESS_GAIN;
            dash_color_reg       <= RST_DASH_COLOR;
            background_color_reg <= RST_BACKGROUND_COLOR;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_PIXEL_COUNT:      pixel_count_reg      <= cfg_data[CNT_W-1:0];
                REG_GAP_FRACTION:     gap_fraction_reg     <= cfg_data[FRAC_W-1:0];
                REG_DASH_SIZE:        dash_size_reg        <= cfg_data[FRAC_W-1:0];
                REG_FADE_AMOUNT:      fade_amount_reg      <= cfg_data[FRAC_W-1:0];
                REG_BRIGHTNESS_GAIN:  brightness_gain_reg  <= cfg_data[FRAC_W-1:0];
                REG_DASH_COLOR:       dash_color_reg       <= cfg_data[COLOR_W-1:0];
                REG_BACKGROUND_COLOR: background_color_reg <= cfg_data[COLOR_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        cfg.count = (pixel_count_reg > MAX_COUNT) ? MAX_COUNT : pixel_count_reg;
        cfg.gap   = gap_fraction_reg;
        cfg.size  = dash_size_reg;
        cfg.fade  = (fade_amount_reg > ONE) ? ONE : fade_amount_reg;
        cfg.gain  = (brightness_gain_reg > ONE) ? ONE : brightness_gain_reg;
        cfg.dash  = dash_color_reg;
        cfg.back  = background_color_reg;
    end

    // The whole pipeline advances unless the skid entry is occupied.
    assign pipe_en = !skid_valid_reg;
    assign s_ready = pipe_en;

    always_comb begin
        in_ctl.valid = s_valid;
        in_ctl.idx   = s_pixel_index;
        in_ctl.bg    = 1'b0;
    end

    mdp_position u_position (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (pipe_en),
        .cfg      (cfg),
        .in_ctl   (in_ctl),
        .in_time  (s_time_phase),
        .out_ctl  (pos_ctl),
        .out_time (pos_time),
        .out_pos  (pos_val)
    );

    mdp_phase u_phase (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (pipe_en),
        .cfg       (cfg),
        .in_ctl    (pos_ctl),
        .in_time   (pos_time),
        .in_pos    (pos_val),
        .out_ctl   (phase_ctl),
        .out_two_d (two_d)
    );

    mdp_term u_term (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (pipe_en),
        .cfg      (cfg),
        .in_ctl   (phase_ctl),
        .in_two_d (two_d),
        .out_ctl  (term_ctl),
        .out_v    (v_val)
    );

    mdp_shade u_shade (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (pipe_en),
        .cfg       (cfg),
        .in_ctl    (term_ctl),
        .in_v      (v_val),
        .out_valid (tail_valid),
        .out_item  (tail_item)
    );

    // The pipeline tail leaves its stage only on an edge where the pipeline moves.
    assign tail_push = pipe_en && tail_valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (!m_valid_reg || m_ready) begin
                if (skid_valid_reg) begin
                    out_reg        <= skid_reg;
                    m_valid_reg    <= 1'b1;
                    skid_valid_reg <= 1'b0;
                end else begin
                    out_reg     <= tail_item;
                    m_valid_reg <= tail_push;
                end
            end else if (tail_push) begin
                skid_reg       <= tail_item;
                skid_valid_reg <= 1'b1;
            end
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_pixel_echo = out_reg.idx;
    assign m_red        = out_reg.rgb[2*CH_W +: CH_W];
    assign m_green      = out_reg.rgb[CH_W +: CH_W];
    assign m_blue       = out_reg.rgb[0 +: CH_W];
    assign m_lit        = out_reg.lit;

    `ASSERT_CLK(a_skid_behind_output, skid_valid_reg |-> m_valid_reg, "skid entry holds a transaction while the output register is empty")
    `ASSERT_CLK(a_stall_fills_skid, (m_valid_reg && !m_ready && tail_push) |=> skid_valid_reg, "pipeline tail was dropped during an output stall")
    `ASSERT_CLK(a_skid_drains, (skid_valid_reg && m_ready) |=> (m_valid_reg && !skid_valid_reg), "skid entry did not move to the output register")
    `ASSERT_CLK_ALWAYS(a_reset_empties, !aresetn |=> (!m_valid_reg && !skid_valid_reg), "output side not empty after reset")

endmodule
